// ----- rtl/cwl_pkg.sv -----
// Shared types and constants of the checksummed word link.
package cwl_pkg;

  // Command codes of an input item
  localparam logic CmdSend = 1'b0;
  localparam logic CmdLine = 1'b1;

  // Answer bytes on the line
  localparam logic [7:0] AnsGood = 8'h67;
  localparam logic [7:0] AnsBad  = 8'h62;

  // Frame geometry
  localparam int unsigned FrameLen  = 5;
  localparam int unsigned DataBytes = FrameLen - 1;
  localparam int unsigned IdxW      = $clog2(FrameLen);

  // Compact description of the results one input item causes
  typedef struct packed {
    logic        is_frame;    // emit the full frame of word
    logic [31:0] word;        // frame word, or received word
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        word_valid;
    logic        send_done;
    logic        rejected;
  } burst_t;

  // XOR of the four bytes of a word
  function automatic logic [7:0] word_xor(input logic [31:0] w);
    word_xor = w[31:24] ^ w[23:16] ^ w[15:8] ^ w[7:0];
  endfunction

endpackage

// ----- rtl/cwl_proto.sv -----
// Link protocol state: send/answer tracking and frame reception.
module cwl_proto (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic            command_i,
  input  logic [31:0]     word_in_i,
  input  logic [7:0]      line_byte_i,
  output logic            burst_valid_o,
  output cwl_pkg::burst_t burst_o
);
  import cwl_pkg::*;

  logic        awaiting_q, awaiting_d;
  logic [2:0]  count_q, count_d;
  logic [31:0] shift_q, shift_d;
  logic [7:0]  xor_q, xor_d;
  logic [31:0] held_q, held_d;

  // Decide next state and the results of the item
  always_comb begin
    awaiting_d    = awaiting_q;
    count_d       = count_q;
    shift_d       = shift_q;
    xor_d         = xor_q;
    held_d        = held_q;
    burst_valid_o = 1'b0;
    burst_o       = '0;
    if (command_i == CmdSend) begin
      burst_valid_o = 1'b1;
      if (awaiting_q) begin
        burst_o.rejected = 1'b1;
      end else begin
        count_d          = '0;
        shift_d          = '0;
        xor_d            = '0;
        held_d           = word_in_i;
        awaiting_d       = 1'b1;
        burst_o.is_frame = 1'b1;
        burst_o.word     = word_in_i;
      end
    end else if (awaiting_q) begin
      burst_valid_o = 1'b1;
      if (line_byte_i == AnsGood) begin
        awaiting_d        = 1'b0;
        burst_o.send_done = 1'b1;
      end else begin
        burst_o.is_frame = 1'b1;
        burst_o.word     = held_q;
      end
    end else if (count_q < 3'(DataBytes)) begin
      shift_d = {shift_q[23:0], line_byte_i};
      xor_d   = xor_q ^ line_byte_i;
      count_d = count_q + 3'd1;
    end else begin
      burst_valid_o    = 1'b1;
      count_d          = '0;
      shift_d          = '0;
      xor_d            = '0;
      burst_o.tx_valid = 1'b1;
      if (xor_q == line_byte_i) begin
        burst_o.tx_byte    = AnsGood;
        burst_o.word_valid = 1'b1;
        burst_o.word       = shift_q;
      end else begin
        burst_o.tx_byte = AnsBad;
      end
    end
  end

  // Commit state on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      count_q    <= '0;
      shift_q    <= '0;
      xor_q      <= '0;
      held_q     <= '0;
    end else if (fire_i) begin
      awaiting_q <= awaiting_d;
      count_q    <= count_d;
      shift_q    <= shift_d;
      xor_q      <= xor_d;
      held_q     <= held_d;
    end
  end

endmodule

// ----- rtl/cwl_tx.sv -----
// Result register and serializer that plays out one burst of results.
module cwl_tx (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  cwl_pkg::burst_t burst_i,
  output logic            busy_o,
  output logic            done_o,
  input  logic            out_stall_i,
  output logic            tx_valid_o,
  output logic [7:0]      tx_byte_o,
  output logic            word_valid_o,
  output logic [31:0]     word_out_o,
  output logic            send_done_o,
  output logic            rejected_o,
  output logic            last_o
);
  import cwl_pkg::*;

  burst_t          burst_q;
  logic            busy_q;
  logic [IdxW-1:0] idx_q;
  logic            take;
  logic [7:0]      frame_byte;

  // Pick the frame byte, most significant first, checksum last
  always_comb begin
    case (idx_q)
      IdxW'(0): frame_byte = burst_q.word[31:24];
      IdxW'(1): frame_byte = burst_q.word[23:16];
      IdxW'(2): frame_byte = burst_q.word[15:8];
      IdxW'(3): frame_byte = burst_q.word[7:0];
      default:  frame_byte = word_xor(burst_q.word);
    endcase
  end

  // Drive the current result
  always_comb begin
    if (burst_q.is_frame) begin
      tx_valid_o   = 1'b1;
      tx_byte_o    = frame_byte;
      word_valid_o = 1'b0;
      word_out_o   = '0;
      send_done_o  = 1'b0;
      rejected_o   = 1'b0;
      last_o       = (idx_q == IdxW'(FrameLen - 1));
    end else begin
      tx_valid_o   = burst_q.tx_valid;
      tx_byte_o    = burst_q.tx_byte;
      word_valid_o = burst_q.word_valid;
      word_out_o   = burst_q.word_valid ? burst_q.word : 32'd0;
      send_done_o  = burst_q.send_done;
      rejected_o   = burst_q.rejected;
      last_o       = 1'b1;
    end
  end

  assign take   = busy_q && !out_stall_i;
  assign done_o = take && last_o;
  assign busy_o = busy_q;

  // Load a new burst, advance within a frame, drop when finished
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (take) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  // Hold the burst payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

endmodule

// ----- rtl/checksummed_word_link.sv -----
// Checksummed word link top level: 5-byte frames with stop-and-wait answer.
// Results of an item start in the cycle after it is accepted.
// A send or resend plays out 5 results from the output register; other items give
// a single result, and line bytes that only fill a frame give none.
// The next item is accepted in the cycle the last pending result is taken.
// Reset (async, active low) clears protocol state and empties the output.
module checksummed_word_link (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [31:0] word_in_i,
  input  logic [7:0]  line_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        word_valid_o,
  output logic [31:0] word_out_o,
  output logic        send_done_o,
  output logic        rejected_o,
  output logic        last_o
);
  import cwl_pkg::*;

  logic   in_fire;
  logic   burst_valid;
  burst_t burst;
  logic   busy;
  logic   done;

  // Accept when the output register is free or frees this cycle
  assign in_stall_o  = busy && !done;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = busy;

  cwl_proto u_proto (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (in_fire),
    .command_i     (command_i),
    .word_in_i     (word_in_i),
    .line_byte_i   (line_byte_i),
    .burst_valid_o (burst_valid),
    .burst_o       (burst)
  );

  cwl_tx u_tx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_fire && burst_valid),
    .burst_i      (burst),
    .busy_o       (busy),
    .done_o       (done),
    .out_stall_i  (out_stall_i),
    .tx_valid_o   (tx_valid_o),
    .tx_byte_o    (tx_byte_o),
    .word_valid_o (word_valid_o),
    .word_out_o   (word_out_o),
    .send_done_o  (send_done_o),
    .rejected_o   (rejected_o),
    .last_o       (last_o)
  );

endmodule
